// File: design/ldw_pkg.sv
package ldw_pkg;

    // Deepest window the block can hold.
    localparam int WINDOW_MAX = 256;

    // Cell index width and length width (a length can equal WINDOW_MAX).
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);

    // Field widths of the words on the ports.
    localparam int VALUE_W   = 32;
    localparam int OUT_LEN_W = 9;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      start_req;
    } t_in_word;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] window_length;
        logic [OUT_LEN_W-1:0] best_length;
        logic                 overflow;
    } t_out_word;

    // Contents of one window cell, handed from a cell to its older neighbor.
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } t_cell;

    // Broadcast from the control logic to every cell.
    typedef struct packed {
        logic shift;
        t_len new_len;
    } t_update;

    // Low OUT_LEN_W bits of an internal length, zero-extended if narrower.
    function automatic logic [OUT_LEN_W-1:0] to_out_len(input t_len len);
        logic [OUT_LEN_W+LEN_W-1:0] wide;
        wide = {{OUT_LEN_W{1'b0}}, len};
        return wide[OUT_LEN_W-1:0];
    endfunction

endpackage

// File: design/ldw_cell.sv
module ldw_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ldw_pkg::t_idx                        i_index,
    input  ldw_pkg::t_cell                       i_prev,
    input  logic signed [ldw_pkg::VALUE_W-1:0]   i_probe,
    input  logic                                 i_clear,
    input  ldw_pkg::t_update                     i_upd,
    output logic                                 o_match,
    output ldw_pkg::t_cell                       o_state
);

    logic                               r_valid;
    logic signed [ldw_pkg::VALUE_W-1:0] r_value;
    logic                               n_valid;

    // A start request hides the whole window from the compare.
    assign o_match = r_valid && !i_clear && (r_value == i_probe);

    // After a shift this cell holds an entry only if it lies inside the new length.
    assign n_valid = i_prev.valid && (ldw_pkg::t_len'(i_index) < i_upd.new_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_upd.shift) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.shift) begin
            r_value <= i_prev.value;
        end
    end

    assign o_state.valid = r_valid;
    assign o_state.value = r_value;

endmodule

// File: design/ldw_outq.sv
module ldw_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ldw_pkg::t_out_word i_word,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_ready,
    output ldw_pkg::t_out_word o_word
);

    ldw_pkg::t_out_word r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;
    logic               w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_word  = r_mem[r_rp];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule

// File: design/longest_distinct_window_core.sv
// Longest repeat-free window over a stream of signed 32-bit words.
//
// The input channel (i_in_valid / o_in_ready / i_in_word) carries one value
// and a start_req bit. start_req clears the window and the best length
// before its value is taken. For every accepted word the output channel
// (o_out_valid / i_out_ready / o_out_word) returns one word with the length
// of the repeat-free window ending at that value, the best length since the
// sequence started, and an overflow bit that is set when the window was full
// and its oldest entry had to be dropped.
//
// The window lives in a chain of WINDOW_MAX cells, newest at cell 0. All
// cells compare the incoming value at once, and the whole window shifts one
// cell toward the old end in the same cycle, so a new word can be accepted every
// cycle while o_in_ready is high. The compare, the one-hot encode of the
// matching cell and the length update form the loop that sets this rate.
// Each result is registered in the output queue before it reaches the output.
//
// A two-word output queue parts the channels: input is accepted while one
// result waits, and o_in_ready drops only when two results are waiting.
// Reset empties the window, clears both lengths and empties the queue.
module longest_distinct_window_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ldw_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ldw_pkg::t_out_word o_out_word
);

    localparam int N = ldw_pkg::WINDOW_MAX;

    // Length of the current window and best length since the sequence start.
    ldw_pkg::t_len      r_len;
    ldw_pkg::t_len      r_best;
    ldw_pkg::t_len      n_len;
    ldw_pkg::t_len      n_best;

    logic               w_accept;
    logic               w_full_q;
    logic [N-1:0]       w_match;
    logic               w_hit;
    ldw_pkg::t_idx      w_hit_idx;
    ldw_pkg::t_len      w_cur_len;
    ldw_pkg::t_len      w_cur_best;
    logic               w_win_full;
    logic               w_ovf;
    ldw_pkg::t_update   w_upd;
    ldw_pkg::t_cell     w_prev  [N];
    ldw_pkg::t_cell     w_state [N];
    ldw_pkg::t_out_word w_result;

    assign o_in_ready = !w_full_q;
    assign w_accept   = i_in_valid && o_in_ready;

    // The cell chain. Cell 0 takes the incoming value; every other cell takes
    // the contents of its newer neighbor on each accepted word.
    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g].valid = 1'b1;
            assign w_prev[g].value = i_in_word.value;
        end else begin : g_body
            assign w_prev[g] = w_state[g-1];
        end

        ldw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (ldw_pkg::t_idx'(g)),
            .i_prev  (w_prev[g]),
            .i_probe (i_in_word.value),
            .i_clear (i_in_word.start_req),
            .i_upd   (w_upd),
            .o_match (w_match[g]),
            .o_state (w_state[g])
        );
    end

    // The window never holds a value twice, so at most one cell matches and
    // an OR over the matching indexes gives its position from the newest end.
    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | ldw_pkg::t_idx'(i);
            end
        end
    end

    assign w_hit = |w_match;

    // A start request sees an empty window and a zero best length.
    assign w_cur_len  = i_in_word.start_req ? '0 : r_len;
    assign w_cur_best = i_in_word.start_req ? '0 : r_best;
    assign w_win_full = (w_cur_len == ldw_pkg::t_len'(N));

    // On a repeat the window keeps the entries newer than the earlier copy
    // plus the new value. Otherwise it grows by one, or when full it drops its
    // oldest entry and keeps its length.
    always_comb begin
        if (w_hit) begin
            n_len = ldw_pkg::t_len'(w_hit_idx) + ldw_pkg::t_len'(1);
        end else if (w_win_full) begin
            n_len = w_cur_len;
        end else begin
            n_len = w_cur_len + ldw_pkg::t_len'(1);
        end
        n_best = (n_len > w_cur_best) ? n_len : w_cur_best;
    end

    assign w_ovf = !w_hit && w_win_full;

    assign w_upd.shift   = w_accept;
    assign w_upd.new_len = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_best <= '0;
        end else if (w_accept) begin
            r_len  <= n_len;
            r_best <= n_best;
        end
    end

    assign w_result.window_length = ldw_pkg::to_out_len(n_len);
    assign w_result.best_length   = ldw_pkg::to_out_len(n_best);
    assign w_result.overflow      = w_ovf;

    ldw_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_word  (w_result),
        .o_full  (w_full_q),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    // The best length never falls below the current window length.
    a_best_covers_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best >= r_len)
        else $error("best length below current window length");

    // The window never grows past its depth.
    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= ldw_pkg::t_len'(N))
        else $error("window length exceeds window depth");

    // Every accepted word leaves a non-empty window behind.
    a_len_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_len != '0))
        else $error("window empty after an accepted word");

    // The newest cell holds an entry exactly when the window is non-empty.
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state[0].valid == (r_len != '0))
        else $error("head cell valid bit disagrees with window length");

    // Input stalls only while results are waiting at the output.
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

// File: dv/ldw_window_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the core, keeps its own copy of the window and
// compares every returned word with the oldest predicted one.
module ldw_window_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ldw_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ldw_pkg::t_out_word i_out_word,
    output int                 o_pending,
    output int                 o_fail_count
);

    import ldw_pkg::*;

    logic [VALUE_W-1:0] win_vals [WINDOW_MAX];
    int                 win_len;
    int                 best_len;
    t_out_word          expected_lengths [$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    // Applies one word to the window copy and returns the word the core owes.
    function automatic t_out_word slide_window(input t_in_word w);
        t_out_word          res;
        logic [VALUE_W-1:0] v;
        int                 hit_at;
        int                 drop;
        int                 k;
        v            = w.value;
        hit_at       = -1;
        drop         = 0;
        res.overflow = 1'b0;
        if (w.start_req) begin
            win_len  = 0;
            best_len = 0;
        end
        for (k = 0; k < win_len; k++) begin
            if (hit_at < 0 && win_vals[k] == v) begin
                hit_at = k;
            end
        end
        if (hit_at >= 0) begin
            drop = hit_at + 1;
        end else if (win_len >= WINDOW_MAX) begin
            drop         = 1;
            res.overflow = 1'b1;
        end
        for (k = 0; k + drop < win_len; k++) begin
            win_vals[k] = win_vals[k + drop];
        end
        win_len           = win_len - drop;
        win_vals[win_len] = v;
        win_len           = win_len + 1;
        if (win_len > best_len) begin
            best_len = win_len;
        end
        res.window_length = OUT_LEN_W'(win_len);
        res.best_length   = OUT_LEN_W'(best_len);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            win_len  = 0;
            best_len = 0;
            expected_lengths.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_lengths.size() == 0) begin
                    $error("output word %p arrived with nothing expected", i_out_word);
                    fail_total++;
                end else begin
                    want = expected_lengths.pop_front();
                    if (i_out_word.window_length !== want.window_length) begin
                        $error("window_length: expected %0d, got %0d",
                               want.window_length, i_out_word.window_length);
                        fail_total++;
                    end
                    if (i_out_word.best_length !== want.best_length) begin
                        $error("best_length: expected %0d, got %0d",
                               want.best_length, i_out_word.best_length);
                        fail_total++;
                    end
                    if (i_out_word.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, i_out_word.overflow);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_lengths.push_back(slide_window(i_in_word));
            end
            o_pending <= expected_lengths.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Top of the bench for longest_distinct_window_core. This module only makes
// stimulus and gives the verdict; the checker beside the core predicts every
// output word and compares it.
module tb;

    import ldw_pkg::*;

    // Cycles with no word moving on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET    = 1800;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    int        pending;
    int        fail_count;
    int        sent_words   = 0;
    int        quiet_cycles = 0;

    // While calm is set, neither side inserts idle cycles.
    bit        calm = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    longest_distinct_window_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    ldw_window_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // The receiver stalls at random, about 7 percent of the time, except while calm.
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 7);
    end

    // The watchdog ends the run when nothing has been accepted for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("longest_distinct_window_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one word and returns at the edge where it is accepted. Valid is
    // left high so that a following word goes out without a gap; it drops
    // only inside an idle stretch or a pause.
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic s);
        while (!calm && $urandom_range(0, 99) < 7) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= {v, s};
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        sent_words++;
    endtask

    // Holds the sender off until every predicted word has come back.
    task automatic drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    // Mostly full-width random values, with the corner patterns mixed in.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // A run of distinct values longer than the window, so the oldest entry is
    // pushed out for space. base + k * stride with an odd stride never
    // repeats within 2^32 steps. The run ends with the oldest value still
    // held, which is a repeat into a full window and must not overflow.
    task automatic send_distinct_run(input int run_len);
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] stride;
        int                 k;
        base   = $urandom;
        stride = $urandom | 32'd1;
        for (k = 0; k < run_len; k++) begin
            send_word(base + k * stride, k == 0);
        end
        send_word(base + (run_len - WINDOW_MAX) * stride, 1'b0);
    endtask

    // A sequence drawn from a pool of up to 300 values, so repeats hit at
    // varied depths of the window. Most sequences open with a start; a stray start
    // now and then cuts a sequence short.
    task automatic send_pool_run(input int pool_size, input int run_len);
        logic [VALUE_W-1:0] pool [300];
        int                 k;
        logic               s;
        for (k = 0; k < pool_size; k++) begin
            pool[k] = pick_value();
        end
        for (k = 0; k < run_len; k++) begin
            if (k == 0) begin
                s = ($urandom_range(0, 99) < 85);
            end else begin
                s = ($urandom_range(0, 99) < 2);
            end
            send_word(pool[$urandom_range(0, pool_size - 1)], s);
        end
    endtask

    initial begin
        int kind;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The first words carry no start: after reset the
        // window is already empty, so the stream starts at the first word.
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        // Repeat of the oldest entry, then of a middle one, then immediately.
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        // Start with a value still in the old window, twice in a row.
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        // Values that differ only in the sign bit, only in the low bit, or in every bit.
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);

        // A full window with overflow comes early, then a pause with the
        // sender held off until everything has drained.
        send_distinct_run($urandom_range(WINDOW_MAX + 1, WINDOW_MAX + 40));
        drain_pause();

        while (sent_words < ITEM_TARGET) begin
            calm = (sent_words >= 700 && sent_words < 1100);
            kind = $urandom_range(0, 11);
            if (kind == 0) begin
                send_distinct_run($urandom_range(WINDOW_MAX + 1, WINDOW_MAX + 40));
            end else if (kind < 4) begin
                send_pool_run($urandom_range(25, 300), $urandom_range(20, 120));
            end else begin
                send_pool_run($urandom_range(1, 24), $urandom_range(4, 60));
            end
            if ($urandom_range(0, 9) == 0) begin
                drain_pause();
            end
        end
        calm = 1'b0;

        // Let every predicted word come back, then keep the clock running so that
        // anything unexpected can still show up.
        drain_pause();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("longest_distinct_window_core test passed");
        end else begin
            $display("longest_distinct_window_core test failed");
        end
        $finish;
    end

endmodule
